// ===== hdl/gegb_pkg.sv =====
package gegb_pkg;

	localparam int MAX_VERTICES   = 4096;
	localparam int MAX_PARTITIONS = 16;
	localparam int COUNT_WIDTH    = 24;
	localparam int VID_W          = 12;
	localparam int PART_W         = 4;
	localparam int CELL_W         = 8;
	localparam int NUM_CELLS      = 256;
	localparam int VCNT_W         = 13;
	localparam int PCNT_W         = 5;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	localparam logic REG_VERTEX_COUNT    = 1'b0;
	localparam logic REG_PARTITION_COUNT = 1'b1;

	typedef struct packed {
		logic [VID_W-1:0] src_vertex;
		logic [VID_W-1:0] dest_vertex;
	} in_item_t;

	typedef struct packed {
		logic [PART_W-1:0]      grid_row;
		logic [PART_W-1:0]      grid_col;
		logic [CELL_W-1:0]      cell_index;
		logic [COUNT_WIDTH-1:0] cell_slot;
		logic [COUNT_WIDTH-1:0] src_out_degree;
		logic [COUNT_WIDTH-1:0] dest_in_degree;
		logic [VID_W-1:0]       cell_max_vertex;
		logic                   range_error;
	} out_item_t;

	typedef struct packed {
		logic             index;
		logic [VCNT_W-1:0] data;
	} cfg_wr_t;

endpackage

// ===== hdl/graph_edge_grid_binner.sv =====
// An accepted edge passes through DIVP, PREP, DIVS, DIVD, RD, CRD and WR before its result is
// registered; an edge with a range error has its result registered as it is taken. The shared
// 13-bit restoring divider runs three 13-step divisions (V/P, source block, destination block).
// The input stalls while an edge is in flight or a result waits.
// Reset: arst_n sets V=4096, P=4 and clears out_valid; a clearing pass over all 4096 vertex
// addresses then zeroes the degree and cell stores before the first edge is accepted.
module graph_edge_grid_binner (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  gegb_pkg::in_item_t         in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output gegb_pkg::out_item_t        out_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  gegb_pkg::cfg_wr_t          cfg_data
);

	typedef enum logic [8:0] {
		ST_CLEAR = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_DIVP  = 9'b000000100,
		ST_PREP  = 9'b000001000,
		ST_DIVS  = 9'b000010000,
		ST_DIVD  = 9'b000100000,
		ST_RD    = 9'b001000000,
		ST_CRD   = 9'b010000000,
		ST_WR    = 9'b100000000
	} state_t;

	state_t state_q;
	logic [gegb_pkg::VCNT_W-1:0] vcnt_q;
	logic [gegb_pkg::PCNT_W-1:0] pcnt_q;
	logic [gegb_pkg::VID_W-1:0]  clr_q;
	gegb_pkg::in_item_t          item_q;
	gegb_pkg::out_item_t         res_q;
	logic                        out_valid_q;

	logic [gegb_pkg::VCNT_W-1:0] base_q, split_q, dvd_q, dvs_q, quo_q, rem_q;
	logic [gegb_pkg::PCNT_W-1:0] extra_q, off_q;
	logic [3:0]                  bit_q;
	logic [gegb_pkg::PART_W-1:0] row_q, col_q;
	logic [gegb_pkg::CELL_W-1:0] cell_q;

	logic [gegb_pkg::COUNT_WIDTH-1:0] odeg_mem [gegb_pkg::MAX_VERTICES];
	logic [gegb_pkg::COUNT_WIDTH-1:0] ideg_mem [gegb_pkg::MAX_VERTICES];
	logic [gegb_pkg::COUNT_WIDTH-1:0] ccnt_mem [gegb_pkg::NUM_CELLS];
	logic [gegb_pkg::VID_W-1:0]       cmax_mem [gegb_pkg::NUM_CELLS];
	logic [gegb_pkg::COUNT_WIDTH-1:0] odeg_rd_q, ideg_rd_q, ccnt_rd_q;
	logic [gegb_pkg::VID_W-1:0]       cmax_rd_q;

	logic [gegb_pkg::VCNT_W-1:0]      nv;
	logic [gegb_pkg::PCNT_W-1:0]      np;
	logic                             in_acc, in_err, div_last, sub_ok, op_hi;
	logic [gegb_pkg::VCNT_W-1:0]      big_w, split_w, op_v, op_sp, op_dvd, op_dvs;
	logic [gegb_pkg::PCNT_W-1:0]      op_off;
	logic [gegb_pkg::VCNT_W:0]        rem_sh;
	logic [gegb_pkg::VCNT_W-1:0]      rem_nx, quo_nx, blk;
	logic [gegb_pkg::PART_W-1:0]      blk_sat;
	logic [gegb_pkg::CELL_W-1:0]      cell_w;
	logic [gegb_pkg::VID_W-1:0]       hi, newmax;
	logic [gegb_pkg::COUNT_WIDTH-1:0] odeg_n, ideg_n, ccnt_n;

	always_comb begin
		nv = (vcnt_q == '0) ? gegb_pkg::VCNT_W'(1)
			: (vcnt_q > gegb_pkg::VCNT_W'(gegb_pkg::MAX_VERTICES))
			? gegb_pkg::VCNT_W'(gegb_pkg::MAX_VERTICES) : vcnt_q;
		np = (pcnt_q == '0) ? gegb_pkg::PCNT_W'(1)
			: (pcnt_q > gegb_pkg::PCNT_W'(gegb_pkg::MAX_PARTITIONS))
			? gegb_pkg::PCNT_W'(gegb_pkg::MAX_PARTITIONS) : pcnt_q;
		in_acc = in_valid && !in_stall;
		in_err = ({1'b0, in_data.src_vertex} >= nv) || ({1'b0, in_data.dest_vertex} >= nv);
		big_w = base_q + gegb_pkg::VCNT_W'(1);
		split_w = gegb_pkg::VCNT_W'(extra_q) * big_w;
		op_v = (state_q == ST_PREP) ? {1'b0, item_q.src_vertex} : {1'b0, item_q.dest_vertex};
		op_sp = (state_q == ST_PREP) ? split_w : split_q;
		op_hi = (extra_q != '0) && (op_v >= op_sp);
		op_dvd = op_hi ? op_v - op_sp : op_v;
		op_dvs = ((extra_q == '0) || op_hi) ? base_q : big_w;
		op_off = op_hi ? extra_q : '0;
		rem_sh = {rem_q, dvd_q[gegb_pkg::VCNT_W-1]};
		sub_ok = rem_sh >= {1'b0, dvs_q};
		rem_nx = sub_ok ? gegb_pkg::VCNT_W'(rem_sh - {1'b0, dvs_q})
			: rem_sh[gegb_pkg::VCNT_W-1:0];
		quo_nx = {quo_q[gegb_pkg::VCNT_W-2:0], sub_ok};
		div_last = (bit_q == '0);
		blk = quo_nx + gegb_pkg::VCNT_W'(off_q);
		blk_sat = (blk >= gegb_pkg::VCNT_W'(np))
			? gegb_pkg::PART_W'(np - gegb_pkg::PCNT_W'(1)) : gegb_pkg::PART_W'(blk);
		cell_w = gegb_pkg::CELL_W'(row_q) * gegb_pkg::CELL_W'(np) + gegb_pkg::CELL_W'(col_q);
		hi = (item_q.src_vertex > item_q.dest_vertex) ? item_q.src_vertex : item_q.dest_vertex;
		newmax = (hi > cmax_rd_q) ? hi : cmax_rd_q;
		odeg_n = (odeg_rd_q == gegb_pkg::COUNT_MAX) ? odeg_rd_q
			: odeg_rd_q + gegb_pkg::COUNT_WIDTH'(1);
		ideg_n = (ideg_rd_q == gegb_pkg::COUNT_MAX) ? ideg_rd_q
			: ideg_rd_q + gegb_pkg::COUNT_WIDTH'(1);
		ccnt_n = (ccnt_rd_q == gegb_pkg::COUNT_MAX) ? ccnt_rd_q
			: ccnt_rd_q + gegb_pkg::COUNT_WIDTH'(1);
	end

	assign in_stall  = (state_q != ST_IDLE) || out_valid_q;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			vcnt_q      <= gegb_pkg::VCNT_W'(gegb_pkg::MAX_VERTICES);
			pcnt_q      <= gegb_pkg::PCNT_W'(4);
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			item_q      <= '0;
			res_q       <= '0;
			base_q      <= '0;
			split_q     <= '0;
			dvd_q       <= '0;
			dvs_q       <= '0;
			quo_q       <= '0;
			rem_q       <= '0;
			extra_q     <= '0;
			off_q       <= '0;
			bit_q       <= '0;
			row_q       <= '0;
			col_q       <= '0;
			cell_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_data.index)
					gegb_pkg::REG_VERTEX_COUNT:    vcnt_q <= cfg_data.data;
					gegb_pkg::REG_PARTITION_COUNT: pcnt_q <= cfg_data.data[gegb_pkg::PCNT_W-1:0];
				endcase
			end
			if (out_valid_q) begin
				if (!out_stall)
					out_valid_q <= 1'b0;
			end else if (((state_q == ST_IDLE) && in_acc && in_err) || (state_q == ST_WR)) begin
				out_valid_q <= 1'b1;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + gegb_pkg::VID_W'(1);
					if (clr_q == '1)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_acc) begin
						item_q <= in_data;
						if (in_err) begin
							res_q <= '{range_error: 1'b1, default: '0};
						end else begin
							state_q <= ST_DIVP;
							dvd_q   <= nv;
							dvs_q   <= gegb_pkg::VCNT_W'(np);
							rem_q   <= '0;
							quo_q   <= '0;
							bit_q   <= 4'(gegb_pkg::VCNT_W - 1);
						end
					end
				end
				ST_DIVP, ST_DIVS, ST_DIVD: begin
					if (div_last) begin
						bit_q <= 4'(gegb_pkg::VCNT_W - 1);
						rem_q <= '0;
						quo_q <= '0;
						unique case (state_q)
							ST_DIVP: begin
								base_q  <= quo_nx;
								extra_q <= gegb_pkg::PCNT_W'(rem_nx);
								state_q <= ST_PREP;
							end
							ST_DIVS: begin
								row_q   <= blk_sat;
								dvd_q   <= op_dvd;
								dvs_q   <= op_dvs;
								off_q   <= op_off;
								state_q <= ST_DIVD;
							end
							default: begin
								col_q   <= blk_sat;
								state_q <= ST_RD;
							end
						endcase
					end else begin
						bit_q <= bit_q - 4'(1);
						dvd_q <= {dvd_q[gegb_pkg::VCNT_W-2:0], 1'b0};
						rem_q <= rem_nx;
						quo_q <= quo_nx;
					end
				end
				ST_PREP: begin
					split_q <= split_w;
					dvd_q   <= op_dvd;
					dvs_q   <= op_dvs;
					off_q   <= op_off;
					state_q <= ST_DIVS;
				end
				ST_RD: begin
					cell_q  <= cell_w;
					state_q <= ST_CRD;
				end
				ST_CRD: state_q <= ST_WR;
				ST_WR: begin
					res_q <= '{grid_row: row_q, grid_col: col_q, cell_index: cell_q,
						cell_slot: ccnt_rd_q, src_out_degree: odeg_n, dest_in_degree: ideg_n,
						cell_max_vertex: newmax, range_error: 1'b0};
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// clear sweep, read-modify-write of the stores
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			odeg_mem[clr_q] <= '0;
			ideg_mem[clr_q] <= '0;
			ccnt_mem[clr_q[gegb_pkg::CELL_W-1:0]] <= '0;
			cmax_mem[clr_q[gegb_pkg::CELL_W-1:0]] <= '0;
		end else if (state_q == ST_WR) begin
			odeg_mem[item_q.src_vertex]  <= odeg_n;
			ideg_mem[item_q.dest_vertex] <= ideg_n;
			ccnt_mem[cell_q]             <= ccnt_n;
			cmax_mem[cell_q]             <= newmax;
		end
		if (state_q == ST_RD) begin
			odeg_rd_q <= odeg_mem[item_q.src_vertex];
			ideg_rd_q <= ideg_mem[item_q.dest_vertex];
		end
		if (state_q == ST_CRD) begin
			ccnt_rd_q <= ccnt_mem[cell_q];
			cmax_rd_q <= cmax_mem[cell_q];
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("accept while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state not one-hot");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.range_error |-> (out_data.cell_slot == '0)
		&& (out_data.grid_row == '0))
		else $error("dropped edge carries data");

endmodule
